// ===== rtl/core/sha1s_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 stream hasher.
// Used by the message buffer, the round unit and the top level. No dependencies.
package sha1s_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] hash_t;

    localparam int unsigned COUNT_W = 61;
    localparam int unsigned ROUNDS  = 80;
    localparam int unsigned ROUND_W = 7;
    localparam int unsigned IDX_W   = 3;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ROUND_W-1:0] round_t;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;
    localparam round_t ROUND_LAST = round_t'(ROUNDS - 1);

    // Byte position of the last byte of a block, and the first position at
    // which the length field no longer fits behind the pad byte.
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    localparam byte unsigned PAD_BYTE = 8'h80;

    localparam hash_t INIT_HASH = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Control word from the sequencer to the message buffer.
    typedef struct packed {
        logic        wr_byte;     // write byte_val at pos
        logic        pad;         // 0x80 at pos, zeros behind it
        logic        clear_head;  // zero words 0 to 13
        logic        wr_len;      // bit length into words 14 and 15
        logic        shift;       // advance the rolling schedule
        logic [5:0]  pos;
        logic [7:0]  byte_val;
        logic [63:0] bit_len;
    } sched_ctl_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t round_k(input logic [1:0] phase);
        word_t k;
        case (phase)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/sha1s_sched.sv =====
// Sixteen-word message block buffer with byte writes, padding and the
// rolling SHA-1 message schedule. Depends on sha1s_pkg.
module sha1s_sched
    import sha1s_pkg::*;
(
    input  logic       clk,
    input  sched_ctl_t ctl,
    output word_t      w0
);

    word_t blk_reg  [16];
    word_t blk_next [16];

    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            blk_next[w] = blk_reg[w];
        end

        if (ctl.shift)
        begin
            for (int j = 0; j < 15; j++)
            begin
                blk_next[j] = blk_reg[j+1];
            end
            blk_next[15] = rotl(blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0], 1);
        end

        // Bytes are packed big-endian: byte 0 of a word sits in its top bits.
        for (int w = 0; w < 16; w++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (ctl.wr_byte && (ctl.pos == 6'(w * 4 + k)))
                begin
                    blk_next[w][31-8*k -: 8] = ctl.byte_val;
                end
                if (ctl.pad)
                begin
                    if (ctl.pos == 6'(w * 4 + k))
                    begin
                        blk_next[w][31-8*k -: 8] = PAD_BYTE;
                    end
                    else if (6'(w * 4 + k) > ctl.pos)
                    begin
                        blk_next[w][31-8*k -: 8] = 8'h00;
                    end
                end
            end
        end

        if (ctl.clear_head)
        begin
            for (int w = 0; w < 14; w++)
            begin
                blk_next[w] = '0;
            end
        end

        if (ctl.wr_len)
        begin
            blk_next[14] = ctl.bit_len[63:32];
            blk_next[15] = ctl.bit_len[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < 16; w++)
        begin
            blk_reg[w] <= blk_next[w];
        end
    end

    assign w0 = blk_reg[0];

endmodule

// ===== rtl/core/sha1s_round.sv =====
// SHA-1 round unit: the five working variables and one round of logic,
// used eighty times per block. Depends on sha1s_pkg.
module sha1s_round
    import sha1s_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  logic   step,
    input  hash_t  init,
    input  round_t round,
    input  word_t  w,
    output hash_t  work
);

    hash_t      work_reg;
    hash_t      work_next;
    logic [1:0] phase;
    word_t      f;
    word_t      a;
    word_t      b;
    word_t      c;
    word_t      d;
    word_t      e;

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];

    always_comb
    begin
        if (round < round_t'(20))
        begin
            phase = 2'd0;
        end
        else if (round < round_t'(40))
        begin
            phase = 2'd1;
        end
        else if (round < round_t'(60))
        begin
            phase = 2'd2;
        end
        else
        begin
            phase = 2'd3;
        end

        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase

        work_next = work_reg;
        if (load)
        begin
            work_next = init;
        end
        else if (step)
        begin
            work_next[0] = rotl(a, 5) + f + e + round_k(phase) + w;
            work_next[1] = a;
            work_next[2] = rotl(b, 30);
            work_next[3] = c;
            work_next[4] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule

// ===== rtl/core/sha1_stream_hasher_core.sv =====
// SHA-1 stream hasher, top level: sequencer, hash and byte count, output register.
// The 64th byte of a block starts the rounds on the single round unit, then an add
// step. Finish runs one or two compressions, then the five digest words leave at
// one per cycle while m_tready allows. Uses sha1s_pkg, sha1s_sched, sha1s_round.
// Reset (rst_n, asynchronous, active low) loads the initial hash, clears the byte
// count and the control state; the block buffer holds no reset value.
module sha1_stream_hasher_core
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    // Sequencer states. IDLE is the only state in which an item is taken.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PAD2  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    round_t            round_reg;
    round_t            round_next;
    logic              fin_reg;
    logic              fin_next;
    logic              two_reg;
    logic              two_next;
    hash_t             hash_reg;
    hash_t             hash_next;
    count_t            count_reg;
    count_t            count_next;
    logic [IDX_W-1:0]  emit_idx_reg;
    logic [IDX_W-1:0]  emit_idx_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    word_t             m_data_reg;
    word_t             m_data_next;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [IDX_W-1:0]  m_idx_next;
    logic              m_last_reg;
    logic              m_last_next;

    logic              accept;
    logic              out_free;
    logic [5:0]        pos;
    sched_ctl_t        sched_ctl;
    logic              rnd_load;
    logic              rnd_step;
    word_t             w0;
    hash_t             work;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign pos      = count_reg[5:0];

    sha1s_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w0  (w0)
    );

    sha1s_round u_round (
        .clk   (clk),
        .load  (rnd_load),
        .step  (rnd_step),
        .init  (hash_reg),
        .round (round_reg),
        .w     (w0),
        .work  (work)
    );

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        fin_next      = fin_reg;
        two_next      = two_reg;
        hash_next     = hash_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        m_data_next   = m_data_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        rnd_load      = 1'b0;
        rnd_step      = 1'b0;

        sched_ctl            = '0;
        sched_ctl.pos        = pos;
        sched_ctl.byte_val   = s_tdata;
        sched_ctl.bit_len    = {count_reg, 3'b000};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_START:
                        begin
                            hash_next  = INIT_HASH;
                            count_next = '0;
                        end
                        OP_DATA:
                        begin
                            sched_ctl.wr_byte = 1'b1;
                            count_next        = count_reg + count_t'(1);
                            // The block is full: compress it.
                            if (pos == POS_LAST)
                            begin
                                rnd_load   = 1'b1;
                                round_next = '0;
                                fin_next   = 1'b0;
                                state_next = ST_ROUND;
                            end
                        end
                        OP_FINISH:
                        begin
                            // Pad, and add the length now if it still fits.
                            sched_ctl.pad    = 1'b1;
                            sched_ctl.wr_len = (pos < POS_LEN);
                            two_next         = (pos >= POS_LEN);
                            fin_next         = 1'b1;
                            rnd_load         = 1'b1;
                            round_next       = '0;
                            state_next       = ST_ROUND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ROUND:
            begin
                rnd_step        = 1'b1;
                sched_ctl.shift = 1'b1;
                round_next      = round_reg + round_t'(1);
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    hash_next[i] = hash_reg[i] + work[i];
                end
                if (fin_reg && two_reg)
                begin
                    two_next   = 1'b0;
                    state_next = ST_PAD2;
                end
                else if (fin_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PAD2:
            begin
                // Length block after a pad that overflowed the first one.
                sched_ctl.clear_head = 1'b1;
                sched_ctl.wr_len     = 1'b1;
                rnd_load             = 1'b1;
                round_next           = '0;
                state_next           = ST_ROUND;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = hash_reg[emit_idx_reg];
                    m_idx_next    = emit_idx_reg;
                    m_last_next   = (emit_idx_reg == IDX_LAST);
                    emit_idx_next = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == IDX_LAST)
                    begin
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            fin_reg      <= 1'b0;
            two_reg      <= 1'b0;
            hash_reg     <= INIT_HASH;
            count_reg    <= '0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            fin_reg      <= fin_next;
            two_reg      <= two_next;
            hash_reg     <= hash_next;
            count_reg    <= count_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= ROUND_LAST))
        else $error("round counter out of range");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == IDX_LAST))
        else $error("last digest word carries the wrong index");

    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_DATA) && (pos == POS_LAST)) |=> (state_reg == ST_ROUND))
        else $error("full block did not start compression");

    a_finish_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (fin_reg && !two_reg))
        else $error("digest emitted outside a finish");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the SHA-1 stream hasher core (sha1_stream_hasher_core).
// It keeps its own SHA-1 predictor in a small scoreboard class and checks every digest word.
// It depends on the sha1s_pkg package and the core RTL only.
`timescale 1ns / 1ps

import sha1s_pkg::*;

// One expected digest word, as it leaves on the result stream.
typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       is_last;
} digest_word_t;

class digest_scoreboard;
    word_t        hash_state[5];
    word_t        block_buf[16];
    count_t       msg_bytes;
    word_t        stage_k[4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6};
    digest_word_t pending_words[$];
    int           mismatch_count;

    function new();
        for (int i = 0; i < 5; i++)
            hash_state[i] = INIT_HASH[i];
        foreach (block_buf[i])
            block_buf[i] = '0;
        msg_bytes      = '0;
        mismatch_count = 0;
    endfunction

    task report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Big-endian byte placement within the 16-word block.
    function void put_byte(input int pos, input logic [7:0] v);
        block_buf[pos / 4][8 * (3 - pos % 4) +: 8] = v;
    endfunction

    // 80 rounds over the block with the rolling schedule, added into the hash.
    function void compress();
        word_t a, b, c, d, e, f, t;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
                f = (b & c) | (~b & d);
            else if (r < 40 || r >= 60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (b & d) | (c & d);
            t = {a[26:0], a[31:27]} + f + e + stage_k[r / 20] + block_buf[0];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
            t = block_buf[13] ^ block_buf[8] ^ block_buf[2] ^ block_buf[0];
            for (int j = 0; j < 15; j++)
                block_buf[j] = block_buf[j + 1];
            block_buf[15] = {t[30:0], t[31]};
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Applies one accepted input item and queues the digest words it causes.
    function void hash_item(input logic [1:0] op, input logic [7:0] data_byte);
        logic [63:0]  bit_len;
        int           pos;
        digest_word_t dw;
        case (op)
            OP_START:
            begin
                for (int i = 0; i < 5; i++)
                    hash_state[i] = INIT_HASH[i];
                msg_bytes = '0;
            end
            OP_DATA:
            begin
                put_byte(int'(msg_bytes[5:0]), data_byte);
                msg_bytes = msg_bytes + 1'b1;
                if (msg_bytes[5:0] == 6'd0)
                    compress();
            end
            OP_FINISH:
            begin
                bit_len = {msg_bytes, 3'b000};
                pos     = int'(msg_bytes[5:0]);
                put_byte(pos, PAD_BYTE);
                for (int i = pos + 1; i < 64; i++)
                    put_byte(i, 8'h00);
                if (pos >= int'(POS_LEN))
                begin
                    compress();
                    for (int i = 0; i < 56; i++)
                        put_byte(i, 8'h00);
                end
                block_buf[14] = bit_len[63:32];
                block_buf[15] = bit_len[31:0];
                compress();
                for (int i = 0; i < 5; i++)
                begin
                    dw.word    = hash_state[i];
                    dw.index   = 3'(i);
                    dw.is_last = (i == 4);
                    pending_words.push_back(dw);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task check_digest_word(input word_t word, input logic [2:0] index,
                           input logic is_last);
        digest_word_t dw;
        if (pending_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word=%08h index=%0d last=%0b",
                                      word, index, is_last));
            return;
        end
        dw = pending_words.pop_front();
        if (word !== dw.word)
            report_mismatch($sformatf("digest word %0d: got %08h, want %08h",
                                      dw.index, word, dw.word));
        if (index !== dw.index)
            report_mismatch($sformatf("word index: got %0d, want %0d", index, dw.index));
        if (is_last !== dw.is_last)
            report_mismatch($sformatf("last flag on word %0d: got %0b, want %0b",
                                      dw.index, is_last, dw.is_last));
    endtask
endclass

module tb;
    // The op code that the block ignores.
    localparam logic [1:0] OP_NOP = 2'd3;

    // Counted input items (ignored ones left out) before the stimulus may stop.
    localparam int ITEM_TARGET   = 230;
    // The last stretch of the run has no idling on either side.
    localparam int CALM_AFTER    = 195;
    // The random part keeps going until at least this many digests were asked for.
    localparam int MIN_FINISHES  = 10;
    // Cycles without any handshake before the run is declared hung. The slowest
    // correct stretch is a two-block finish plus a sender gap and a receiver stall,
    // so this leaves wide margin.
    localparam int STALL_LIMIT   = 1500;
    // Quiet cycles at the end: longer than a two-block finish plus its five words.
    localparam int TAIL_CYCLES   = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = OP_START;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    digest_scoreboard sb = new();

    int items_sent    = 0;
    int finishes_sent = 0;
    int idle_cycles   = 0;
    bit calm          = 1'b0;

    sha1_stream_hasher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Offers one item and holds it until the block takes it. All signals are
    // sampled right after the edge, so they show the values the edge saw. A
    // random gap with tvalid low may come first, except in the calm stretch.
    task automatic send_item(input logic [1:0] op, input logic [7:0] data_byte);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data_byte;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.hash_item(op, data_byte);
        if (op != OP_NOP)
            items_sent++;
        if (op == OP_FINISH)
            finishes_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // A start, a run of random bytes with the odd ignored item mixed in, and a finish.
    task automatic send_message(input int len);
        send_item(OP_START, 8'($urandom));
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(OP_NOP, 8'($urandom));
            send_item(OP_DATA, 8'($urandom));
        end
        send_item(OP_FINISH, 8'($urandom));
    endtask

    // Result side: tready drops for random bursts, with runs of steady
    // readiness in between and none at all once calm.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Every accepted digest word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_digest_word(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog: counts cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int len;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First, bytes with no start: they are hashed from the
        // reset state. The extremes of the data byte go in here.
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_FINISH, 8'h00);
        // A repeated finish works on the finished hash as if the message went on.
        send_item(OP_FINISH, 8'hFF);
        // Data after a finish, an ignored op with all data bits set, another finish.
        send_item(OP_DATA, 8'hA5);
        send_item(OP_NOP, 8'hFF);
        send_item(OP_FINISH, 8'h5A);
        // The empty message.
        send_item(OP_START, 8'hFF);
        send_item(OP_FINISH, 8'h00);
        // The classic three-byte message "abc", with an ignored item inside.
        send_item(OP_START, 8'h00);
        send_item(OP_DATA, 8'h61);
        send_item(OP_DATA, 8'h62);
        send_item(OP_NOP, 8'h00);
        send_item(OP_DATA, 8'h63);
        send_item(OP_FINISH, 8'h00);

        // Random part: mostly well-formed messages. Lengths lean short, with a
        // share around the one-block and two-block boundaries, where the length
        // field stops fitting and an extra compression is needed.
        while (items_sent < ITEM_TARGET || finishes_sent < MIN_FINISHES)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                    5:             len = $urandom_range(55, 64);
                    6:             len = $urandom_range(119, 128);
                    default:       len = $urandom_range(13, 54);
                endcase
                // The last message is cut short so the run stays near its item budget.
                if (items_sent + len > ITEM_TARGET)
                    len = (ITEM_TARGET > items_sent) ? ITEM_TARGET - items_sent : 0;
                send_message(len);
            end
            else
            begin
                // Noise: unframed items of any op, including stray finishes.
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected word, then watch for strays.
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
